FILE: rtl/svgn_pkg.sv
// svgn_pkg: command, segment kind and curve family codes for the path
// segment normalizer. No dependencies.
package svgn_pkg;

	// Width of every coordinate field on the ports.
	localparam int FIELD_W = 32;

	typedef enum logic [3:0] {
		CMD_MOVE   = 4'd0,
		CMD_LINE   = 4'd1,
		CMD_HORIZ  = 4'd2,
		CMD_VERT   = 4'd3,
		CMD_CUBIC  = 4'd4,
		CMD_SCUBIC = 4'd5,
		CMD_QUAD   = 4'd6,
		CMD_SQUAD  = 4'd7,
		CMD_CLOSE  = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		SEG_START = 2'd0,
		SEG_LINE  = 2'd1,
		SEG_CUBIC = 2'd2,
		SEG_CLOSE = 2'd3
	} seg_kind_t;

	// Family of the previous word, for smooth reflection.
	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_CUBIC = 2'd1,
		CLS_QUAD  = 2'd2
	} curve_class_t;

endpackage

FILE: rtl/svgn_div3.sv
// svgn_div3: pipelined (p + 2q) / 3, rounded toward zero, for the quadratic raise.
// Shift-add reciprocal with an 8-bit remainder fixup. No package dependency.
module svgn_div3 #(
	parameter int W = 32,
	localparam int NS = $clog2(W + 1) - 2,
	localparam int NSTG = NS + 5
) (
	input  logic                clk,
	input  logic [NSTG-1:0]     en,
	input  logic signed [W-1:0] p,
	input  logic signed [W-1:0] q,
	output logic signed [W-1:0] quo
);

	localparam int M  = W + 1;   // magnitude width of p + 2q
	localparam int QC = NS + 3;  // fixup stage

	logic signed [W+1:0] n_s0;
	logic signed [W+1:0] nabs;
	logic [M-1:0]        m_s   [1:NS+2];
	logic                neg_s [1:NS+3];
	logic [M-1:0]        acc_s [0:NS];
	logic [M-1:0]        qc_s;
	logic signed [W-1:0] quo_s;
	logic [7:0]          rem;
	logic [15:0]         prod;
	logic [6:0]          corr;

	assign nabs = n_s0[W+1] ? -n_s0 : n_s0;

	// Estimate never exceeds m/3, so the remainder is small and non-negative.
	assign rem  = m_s[NS+2][7:0] - acc_s[NS][7:0] - {acc_s[NS][6:0], 1'b0};
	assign prod = {8'd0, rem} * 16'd171;
	assign corr = prod[15:9];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			n_s0 <= {{2{p[W-1]}}, p} + {q[W-1], q, 1'b0};
		end
		if (en[1]) begin
			neg_s[1] <= n_s0[W+1];
			m_s[1]   <= nabs[M-1:0];
		end
		if (en[2]) begin
			acc_s[0] <= (m_s[1] >> 2) + (m_s[1] >> 4);
			m_s[2]   <= m_s[1];
			neg_s[2] <= neg_s[1];
		end
		// Each step doubles the span of the 1/4 + 1/16 + ... series.
		for (int i = 0; i < NS; i++) begin
			if (en[3+i]) begin
				acc_s[i+1] <= acc_s[i] + (acc_s[i] >> (4 << i));
				m_s[3+i]   <= m_s[2+i];
				neg_s[3+i] <= neg_s[2+i];
			end
		end
		if (en[QC]) begin
			qc_s      <= acc_s[NS] + M'(corr);
			neg_s[QC] <= neg_s[NS+2];
		end
		if (en[QC+1]) begin
			quo_s <= neg_s[QC] ? -qc_s[W-1:0] : qc_s[W-1:0];
		end
	end

	assign quo = quo_s;

endmodule

FILE: rtl/svg_path_segment_normalizer.sv
// svg_path_segment_normalizer: one path command word in, one absolute segment word out.
// Throughput: one word per cycle unless seg_ready stalls the output; the current point
// and control point registers are updated by the saturating adders of the state stage.
// Reset (arst_n low): pipeline valid bits cleared, path state cleared to zero.
// Uses svgn_pkg and svgn_div3.
module svg_path_segment_normalizer
	import svgn_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [3:0]                cmd,
	input  logic                      relative,
	input  logic signed [FIELD_W-1:0] a_x,
	input  logic signed [FIELD_W-1:0] a_y,
	input  logic signed [FIELD_W-1:0] b_x,
	input  logic signed [FIELD_W-1:0] b_y,
	input  logic signed [FIELD_W-1:0] c_x,
	input  logic signed [FIELD_W-1:0] c_y,
	output logic                      seg_valid,
	input  logic                      seg_ready,
	output logic [1:0]                seg_kind,
	output logic signed [FIELD_W-1:0] start_x,
	output logic signed [FIELD_W-1:0] start_y,
	output logic signed [FIELD_W-1:0] ctrl1_x,
	output logic signed [FIELD_W-1:0] ctrl1_y,
	output logic signed [FIELD_W-1:0] ctrl2_x,
	output logic signed [FIELD_W-1:0] ctrl2_y,
	output logic signed [FIELD_W-1:0] end_x,
	output logic signed [FIELD_W-1:0] end_y
);

	// ------------------------------------------------------------------
	// Sizes. Internal coordinates are COORD_WIDTH bits; the wide type holds
	// any sum of a coordinate and a port field, or 2*c - p, without overflow.
	// ------------------------------------------------------------------
	localparam int W    = COORD_WIDTH;
	localparam int XW   = ((W > FIELD_W) ? W : FIELD_W) + 2;
	localparam int DSTG = $clog2(W + 1) + 3;  // divider stages
	localparam int P    = DSTG + 2;           // s1, s2, then the divider

	typedef logic signed [W-1:0]  coord_t;
	typedef logic signed [XW-1:0] wide_t;

	typedef struct packed {
		seg_kind_t kind;
		logic      quad;   // ctrl points come from the divide-by-3 lanes
		coord_t    sx;
		coord_t    sy;
		coord_t    ex;
		coord_t    ey;
		coord_t    c1x;
		coord_t    c1y;
		coord_t    c2x;
		coord_t    c2y;
	} seg_t;

	localparam wide_t WMAX = wide_t'((wide_t'(1) <<< (W - 1)) - wide_t'(1));
	localparam wide_t WMIN = wide_t'(-WMAX - wide_t'(1));

	function automatic wide_t ext_c(coord_t c);
		return wide_t'(c);
	endfunction

	function automatic wide_t ext_f(logic signed [FIELD_W-1:0] f);
		return wide_t'(f);
	endfunction

	function automatic coord_t clamp(wide_t v);
		coord_t r;
		if (v > WMAX) begin
			r = WMAX[W-1:0];
		end else if (v < WMIN) begin
			r = WMIN[W-1:0];
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	// Absolute coordinate of a field; relative adds saturate.
	function automatic coord_t absc(logic signed [FIELD_W-1:0] f, coord_t base, logic rel);
		return clamp(rel ? (ext_c(base) + ext_f(f)) : ext_f(f));
	endfunction

	// Stored control mirrored through the current point, saturated.
	function automatic coord_t reflect(coord_t c, coord_t s);
		return clamp(ext_c(c) + ext_c(c) - ext_c(s));
	endfunction

	function automatic logic signed [FIELD_W-1:0] to_port(coord_t c);
		wide_t t;
		t = ext_c(c);
		return t[FIELD_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Pipeline flow control. A stage loads when it is empty or the stage
	// after it loads, so bubbles fill while a finished word waits.
	// ------------------------------------------------------------------
	logic [P-1:0] vld_q;
	logic [P-1:0] en;

	always_comb begin
		en[P-1] = !vld_q[P-1] || seg_ready;
		for (int k = P - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign item_ready = en[0];

	// Commands above close are taken and dropped: no word, no state change.
	logic cmd_ok;
	assign cmd_ok = (cmd <= CMD_CLOSE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= item_valid && cmd_ok;
			end
			for (int k = 1; k < P; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// s1: input register.
	// ------------------------------------------------------------------
	cmd_t                      cmd_s1;
	logic                      rel_s1;
	logic signed [FIELD_W-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cmd_s1 <= cmd_t'(cmd);
			rel_s1 <= relative;
			ax_s1  <= a_x;
			ay_s1  <= a_y;
			bx_s1  <= b_x;
			by_s1  <= b_y;
			cx_s1  <= c_x;
			cy_s1  <= c_y;
		end
	end

	// ------------------------------------------------------------------
	// Path state: current point, figure start, last controls, family.
	// ------------------------------------------------------------------
	coord_t       cur_x_q, cur_y_q, fig_x_q, fig_y_q;
	coord_t       lcc_x_q, lcc_y_q, lqc_x_q, lqc_y_q;
	curve_class_t cls_q;

	// State stage logic: one absolute segment from the s1 word and the state.
	seg_t         seg_n;
	coord_t       qx_n, qy_n;
	coord_t       fig_x_n, fig_y_n, lcc_x_n, lcc_y_n, lqc_x_n, lqc_y_n;
	curve_class_t cls_n;

	always_comb begin
		seg_n      = '0;
		seg_n.kind = SEG_LINE;
		seg_n.sx   = cur_x_q;
		seg_n.sy   = cur_y_q;
		seg_n.ex   = cur_x_q;
		seg_n.ey   = cur_y_q;
		qx_n       = cur_x_q;
		qy_n       = cur_y_q;
		cls_n      = CLS_NONE;
		fig_x_n    = fig_x_q;
		fig_y_n    = fig_y_q;
		lcc_x_n    = lcc_x_q;
		lcc_y_n    = lcc_y_q;
		lqc_x_n    = lqc_x_q;
		lqc_y_n    = lqc_y_q;
		unique case (cmd_s1)
			CMD_MOVE: begin
				seg_n.kind = SEG_START;
				seg_n.ex   = absc(ax_s1, cur_x_q, rel_s1);
				seg_n.ey   = absc(ay_s1, cur_y_q, rel_s1);
				seg_n.sx   = seg_n.ex;
				seg_n.sy   = seg_n.ey;
				fig_x_n    = seg_n.ex;
				fig_y_n    = seg_n.ey;
			end
			CMD_LINE: begin
				seg_n.ex = absc(ax_s1, cur_x_q, rel_s1);
				seg_n.ey = absc(ay_s1, cur_y_q, rel_s1);
			end
			CMD_HORIZ: begin
				seg_n.ex = absc(ax_s1, cur_x_q, rel_s1);
			end
			CMD_VERT: begin
				seg_n.ey = absc(ay_s1, cur_y_q, rel_s1);
			end
			CMD_CUBIC: begin
				seg_n.kind = SEG_CUBIC;
				seg_n.c1x  = absc(ax_s1, cur_x_q, rel_s1);
				seg_n.c1y  = absc(ay_s1, cur_y_q, rel_s1);
				seg_n.c2x  = absc(bx_s1, cur_x_q, rel_s1);
				seg_n.c2y  = absc(by_s1, cur_y_q, rel_s1);
				seg_n.ex   = absc(cx_s1, cur_x_q, rel_s1);
				seg_n.ey   = absc(cy_s1, cur_y_q, rel_s1);
				cls_n      = CLS_CUBIC;
			end
			CMD_SCUBIC: begin
				seg_n.kind = SEG_CUBIC;
				if (cls_q == CLS_CUBIC) begin
					seg_n.c1x = reflect(cur_x_q, lcc_x_q);
					seg_n.c1y = reflect(cur_y_q, lcc_y_q);
				end else begin
					seg_n.c1x = cur_x_q;
					seg_n.c1y = cur_y_q;
				end
				seg_n.c2x = absc(ax_s1, cur_x_q, rel_s1);
				seg_n.c2y = absc(ay_s1, cur_y_q, rel_s1);
				seg_n.ex  = absc(bx_s1, cur_x_q, rel_s1);
				seg_n.ey  = absc(by_s1, cur_y_q, rel_s1);
				cls_n     = CLS_CUBIC;
			end
			CMD_QUAD: begin
				seg_n.kind = SEG_CUBIC;
				seg_n.quad = 1'b1;
				qx_n       = absc(ax_s1, cur_x_q, rel_s1);
				qy_n       = absc(ay_s1, cur_y_q, rel_s1);
				seg_n.ex   = absc(bx_s1, cur_x_q, rel_s1);
				seg_n.ey   = absc(by_s1, cur_y_q, rel_s1);
				cls_n      = CLS_QUAD;
			end
			CMD_SQUAD: begin
				seg_n.kind = SEG_CUBIC;
				seg_n.quad = 1'b1;
				if (cls_q == CLS_QUAD) begin
					qx_n = reflect(cur_x_q, lqc_x_q);
					qy_n = reflect(cur_y_q, lqc_y_q);
				end
				seg_n.ex = absc(ax_s1, cur_x_q, rel_s1);
				seg_n.ey = absc(ay_s1, cur_y_q, rel_s1);
				cls_n    = CLS_QUAD;
			end
			default: begin
				// close: back to the figure start, relative bit ignored
				seg_n.kind = SEG_CLOSE;
				seg_n.ex   = fig_x_q;
				seg_n.ey   = fig_y_q;
			end
		endcase
		if (cls_n == CLS_CUBIC) begin
			lcc_x_n = seg_n.c2x;
			lcc_y_n = seg_n.c2y;
		end
		if (seg_n.quad) begin
			lqc_x_n = qx_n;
			lqc_y_n = qy_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			fig_x_q <= '0;
			fig_y_q <= '0;
			lcc_x_q <= '0;
			lcc_y_q <= '0;
			lqc_x_q <= '0;
			lqc_y_q <= '0;
			cls_q   <= CLS_NONE;
		end else if (en[1] && vld_q[0]) begin
			cur_x_q <= seg_n.ex;
			cur_y_q <= seg_n.ey;
			fig_x_q <= fig_x_n;
			fig_y_q <= fig_y_n;
			lcc_x_q <= lcc_x_n;
			lcc_y_q <= lcc_y_n;
			lqc_x_q <= lqc_x_n;
			lqc_y_q <= lqc_y_n;
			cls_q   <= cls_n;
		end
	end

	// ------------------------------------------------------------------
	// s2 and the delay line that runs beside the divider.
	// ------------------------------------------------------------------
	seg_t   seg_s [1:P-1];
	coord_t qx_s2, qy_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			seg_s[1] <= seg_n;
			qx_s2    <= qx_n;
			qy_s2    <= qy_n;
		end
		for (int k = 2; k < P; k++) begin
			if (en[k]) begin
				seg_s[k] <= seg_s[k-1];
			end
		end
	end

	// Quadratic raise: ctrl1 = (start + 2q) / 3, ctrl2 = (end + 2q) / 3.
	coord_t lane_p [4];
	coord_t lane_q [4];
	coord_t lane_r [4];

	assign lane_p[0] = seg_s[1].sx;
	assign lane_p[1] = seg_s[1].sy;
	assign lane_p[2] = seg_s[1].ex;
	assign lane_p[3] = seg_s[1].ey;
	assign lane_q[0] = qx_s2;
	assign lane_q[1] = qy_s2;
	assign lane_q[2] = qx_s2;
	assign lane_q[3] = qy_s2;

	for (genvar g = 0; g < 4; g++) begin : g_div
		svgn_div3 #(
			.W(W)
		) u_div3 (
			.clk(clk),
			.en (en[P-1:2]),
			.p  (lane_p[g]),
			.q  (lane_q[g]),
			.quo(lane_r[g])
		);
	end

	// ------------------------------------------------------------------
	// Result word.
	// ------------------------------------------------------------------
	seg_t seg_o;
	assign seg_o = seg_s[P-1];

	assign seg_valid = vld_q[P-1];
	assign seg_kind  = seg_o.kind;
	assign start_x   = to_port(seg_o.sx);
	assign start_y   = to_port(seg_o.sy);
	assign end_x     = to_port(seg_o.ex);
	assign end_y     = to_port(seg_o.ey);
	assign ctrl1_x   = to_port(seg_o.quad ? lane_r[0] : seg_o.c1x);
	assign ctrl1_y   = to_port(seg_o.quad ? lane_r[1] : seg_o.c1y);
	assign ctrl2_x   = to_port(seg_o.quad ? lane_r[2] : seg_o.c2x);
	assign ctrl2_y   = to_port(seg_o.quad ? lane_r[3] : seg_o.c2y);

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	// A bubble anywhere in the pipe means the input side can take a word.
	a_ready_on_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_q) |-> item_ready)
		else $error("input stalled with a free pipeline stage");

	// A figure start ends where it starts.
	a_start_point: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && (seg_kind == SEG_START) |-> (start_x == end_x) && (start_y == end_y))
		else $error("figure start word with differing start and end");

	// Only cubic words carry control points.
	a_ctrl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && (seg_kind != SEG_CUBIC) |->
			(ctrl1_x == '0) && (ctrl1_y == '0) && (ctrl2_x == '0) && (ctrl2_y == '0))
		else $error("control points on a non-cubic word");

endmodule
